// ===== src/at_reply_line_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// AT reply line classifier assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef AT_REPLY_LINE_CLASSIFIER_DEFINES_SVH
`define AT_REPLY_LINE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ARLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ARLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/arlc_pkg.sv =====
// ----------------------------------------------------------------------------
// AT reply line classifier package
// Widths, character codes, pattern tables and the line class codes.
// ----------------------------------------------------------------------------
package arlc_pkg;

    localparam int LINE_MAX   = 96;
    localparam int CNT_W      = $clog2(LINE_MAX);
    localparam int LEN_W      = 7;
    localparam int CLASS_W    = 3;
    localparam int NUM_PREFIX = 6;
    localparam int NUM_EXACT  = 4;
    localparam int PAT_IDX_W  = 4;
    localparam int PAT_DEPTH  = 1 << PAT_IDX_W;

    typedef logic [7:0]           t_byte;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [PAT_IDX_W-1:0] t_plen;

    localparam t_byte  CHR_LF    = 8'h0A;
    localparam t_byte  CHR_SPACE = " ";
    localparam t_byte  CHR_TILDE = "~";
    localparam t_count KEEP_MAX  = CNT_W'(LINE_MAX - 1);

    typedef enum logic [CLASS_W-1:0] {
        CLS_EVENT       = 3'd0,
        CLS_UNSOLICITED = 3'd1,
        CLS_CMD_OK      = 3'd2,
        CLS_CMD_ERROR   = 3'd3,
        CLS_RESPONSE    = 3'd4
    } t_line_class;

    typedef struct packed {
        logic        hit;
        t_line_class cls;
        t_len        len;
    } t_result;

    // Event prefixes, matched from the start of the line.
    localparam t_byte PREFIX_TXT [NUM_PREFIX][PAT_DEPTH] = '{
        '{0:"W", 1:"I", 2:"F", 3:"I", 4:" ", default:8'h00},
        '{0:"+", 1:"I", 2:"P", 3:"D", default:8'h00},
        '{0:"r", 1:"e", 2:"a", 3:"d", 4:"y", default:8'h00},
        '{0:"b", 1:"u", 2:"s", 3:"y", 4:" ", default:8'h00},
        '{0:"+", 1:"C", 2:"W", 3:"J", 4:"A", 5:"P", 6:":", default:8'h00},
        '{0:"S", 1:"E", 2:"N", 3:"D", 4:" ", 5:"F", 6:"A", 7:"I", 8:"L",
          default:8'h00}
    };
    localparam t_plen PREFIX_LEN [NUM_PREFIX] = '{
        4'd5, 4'd4, 4'd5, 4'd5, 4'd7, 4'd9
    };

    // Terminal words: the first two mean ok, the last two mean error.
    localparam t_byte EXACT_TXT [NUM_EXACT][PAT_DEPTH] = '{
        '{0:"O", 1:"K", default:8'h00},
        '{0:"S", 1:"E", 2:"N", 3:"D", 4:" ", 5:"O", 6:"K", default:8'h00},
        '{0:"E", 1:"R", 2:"R", 3:"O", 4:"R", default:8'h00},
        '{0:"F", 1:"A", 2:"I", 3:"L", default:8'h00}
    };
    localparam t_plen EXACT_LEN [NUM_EXACT] = '{
        4'd2, 4'd7, 4'd5, 4'd4
    };

endpackage

// ===== src/arlc_matcher.sv =====
// ----------------------------------------------------------------------------
// AT reply line matcher
// Holds the per-line count and pattern matchers; classifies on line feed.
// ----------------------------------------------------------------------------
module arlc_matcher
    import arlc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_byte   i_rx_byte,
    input  logic    i_command_pending,
    output t_result o_result
);

    t_count                r_count;
    logic [NUM_PREFIX-1:0] r_prefix;
    logic [NUM_EXACT-1:0]  r_exact;
    t_count                n_count;
    logic [NUM_PREFIX-1:0] n_prefix;
    logic [NUM_EXACT-1:0]  n_exact;

    logic                  keep;
    logic                  is_lf;
    logic [NUM_PREFIX-1:0] prefix_done;
    logic [NUM_EXACT-1:0]  word_hit;
    t_line_class           cls;

    assign is_lf = (i_rx_byte == CHR_LF);
    assign keep  = (i_rx_byte >= CHR_SPACE) && (i_rx_byte <= CHR_TILDE)
                && (r_count < KEEP_MAX);

    // Classify on the state before the line feed.
    always_comb begin
        for (int i = 0; i < NUM_PREFIX; i++) begin
            prefix_done[i] = r_prefix[i] && (r_count >= CNT_W'(PREFIX_LEN[i]));
        end
        for (int i = 0; i < NUM_EXACT; i++) begin
            word_hit[i] = r_exact[i] && (r_count == CNT_W'(EXACT_LEN[i]));
        end
        if (|prefix_done) begin
            cls = CLS_EVENT;
        end else if (!i_command_pending) begin
            cls = CLS_UNSOLICITED;
        end else if (word_hit[0] || word_hit[1]) begin
            cls = CLS_CMD_OK;
        end else if (word_hit[2] || word_hit[3]) begin
            cls = CLS_CMD_ERROR;
        end else begin
            cls = CLS_RESPONSE;
        end
    end

    always_comb begin
        n_count       = r_count;
        n_prefix      = r_prefix;
        n_exact       = r_exact;
        o_result.hit  = 1'b0;
        o_result.cls  = cls;
        o_result.len  = LEN_W'(r_count);
        if (is_lf) begin
            if (r_count != '0) begin
                o_result.hit = 1'b1;
                n_count      = '0;
                n_prefix     = '1;
                n_exact      = '1;
            end
        end else if (keep) begin
            // Drop a matcher on the first mismatching character.
            for (int i = 0; i < NUM_PREFIX; i++) begin
                if ((r_count < CNT_W'(PREFIX_LEN[i]))
                    && (PREFIX_TXT[i][r_count[PAT_IDX_W-1:0]] != i_rx_byte)) begin
                    n_prefix[i] = 1'b0;
                end
            end
            for (int i = 0; i < NUM_EXACT; i++) begin
                if ((r_count >= CNT_W'(EXACT_LEN[i]))
                    || (EXACT_TXT[i][r_count[PAT_IDX_W-1:0]] != i_rx_byte)) begin
                    n_exact[i] = 1'b0;
                end
            end
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_prefix <= '1;
            r_exact  <= '1;
        end else if (i_step) begin
            r_count  <= n_count;
            r_prefix <= n_prefix;
            r_exact  <= n_exact;
        end
    end

endmodule

// ===== src/at_reply_line_classifier.sv =====
// A result word reaches o_valid through the input register and then the result register once its line feed is accepted.
// Throughput: one received byte per cycle while no result waits under i_stall; the input
// register, the single-pass matcher update and the result register run together with no bubble.
// A result waiting under i_stall holds the stage behind it; input stalls only then.
// Reset (i_rst_n low, synchronous) empties both registers and clears the line state.
// ----------------------------------------------------------------------------
// AT reply line classifier
// Classifies modem reply lines byte by byte and reports class and kept length.
// ----------------------------------------------------------------------------
`include "at_reply_line_classifier_defines.svh"

module at_reply_line_classifier
    import arlc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_command_pending,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CLASS_W-1:0] o_line_class,
    output logic [LEN_W-1:0]   o_line_length
);

    // Input register: holds one accepted word until the matcher consumes it.
    logic        r_in_valid;
    t_byte       r_byte;
    logic        r_pending;

    // Result register.
    logic        r_out_valid;
    t_line_class r_class;
    t_len        r_length;

    logic        in_take;
    logic        process;
    t_result     result;

    // Consume the held word when the result slot is empty or being drained
    // this cycle; a word that ends no line just advances the line state.
    assign process = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !process;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte    <= i_rx_byte;
            r_pending <= i_command_pending;
        end
    end

    arlc_matcher u_matcher (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (process),
        .i_rx_byte         (r_byte),
        .i_command_pending (r_pending),
        .o_result          (result)
    );

    // Load a result only on a line feed that ends a non-empty line; drop
    // the valid once the consumer takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= result.hit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && result.hit) begin
            r_class  <= result.cls;
            r_length <= result.len;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_line_class  = r_class;
    assign o_line_length = r_length;

    // A finished line always carries at least one kept character.
    `ARLC_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n, o_valid, o_line_length != '0, "empty line reported")

    // Only a line feed can produce a result.
    `ARLC_ASSERT_NEXT(a_lf_only, i_clk, i_rst_n, process && (r_byte != CHR_LF), !o_valid, "result without line feed")

    // Kept length never exceeds the line limit.
    `ARLC_ASSERT_NOW(a_len_max, i_clk, i_rst_n, o_valid, int'(o_line_length) <= (LINE_MAX - 1), "line length over limit")

endmodule
